### rtl/tgad_pkg.sv
package tgad_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_IDSKIP,
		PH_RAW,
		PH_PKTHDR,
		PH_PKTPIX,
		PH_IDLE
	} phase_t;

	localparam logic [1:0] ST_RUN       = 2'd0;
	localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
	localparam logic [1:0] ST_BAD_DEPTH = 2'd2;

	localparam logic [4:0] HDR_ID_LEN    = 5'd0;
	localparam logic [4:0] HDR_TYPE      = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_DEPTH     = 5'd16;
	localparam logic [4:0] HDR_DESC      = 5'd17;
	localparam logic [4:0] HDR_LEN       = 5'd18;

	localparam logic [7:0] TYPE_RAW     = 8'd2;
	localparam logic [7:0] TYPE_RLE     = 8'd10;
	localparam logic [7:0] DEPTH_24     = 8'd24;
	localparam logic [7:0] DEPTH_32     = 8'd32;
	localparam logic [7:0] ORIGIN_MASK  = 8'h30;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       start_of_file;
	} byte_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] pixel_address;
		logic [7:0]  run_length;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last_pixel;
	} run_word_t;

endpackage

### rtl/tgad_byte_if.sv
interface tgad_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       start_of_file;

	modport source (output valid, output byte_value, output start_of_file, input ready);
	modport sink (input valid, input byte_value, input start_of_file, output ready);
endinterface

### rtl/tgad_run_if.sv
interface tgad_run_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] pixel_address;
	logic [7:0]  run_length;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        last_pixel;

	modport source (
		output valid, output status, output pixel_address, output run_length,
		output red, output green, output blue, output alpha,
		output image_width, output image_height, output last_pixel,
		input ready
	);
	modport sink (
		input valid, input status, input pixel_address, input run_length,
		input red, input green, input blue, input alpha,
		input image_width, input image_height, input last_pixel,
		output ready
	);
endinterface

### rtl/tgad_input_stage.sv
module tgad_input_stage (
	input  logic                clk,
	input  logic                arst_n,
	tgad_byte_if.sink           data,
	input  logic                take,
	output logic                valid_s1,
	output tgad_pkg::byte_word_t word_s1
);

	assign data.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.valid && data.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			word_s1.byte_value    <= data.byte_value;
			word_s1.start_of_file <= data.start_of_file;
		end
	end

endmodule

### rtl/tgad_parser.sv
module tgad_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  tgad_pkg::byte_word_t word_s1,
	output logic                 res_valid,
	output tgad_pkg::run_word_t  res
);

	tgad_pkg::phase_t phase_q, c_phase, n_phase;
	logic [4:0]  hcount_q, c_hcount, n_hcount;
	logic [7:0]  idskip_q, c_idskip, n_idskip;
	logic        rle_q, c_rle, n_rle;
	logic [15:0] width_q, c_width, n_width;
	logic [15:0] height_q, c_height, n_height;
	logic        alpha_q, c_alpha, n_alpha;
	logic        flip_q, c_flip, n_flip;
	logic [15:0] row_q, c_row, n_row;
	logic [15:0] col_q, c_col, n_col;
	logic [7:0]  left_q, c_left, n_left;
	logic        rep_q, c_rep, n_rep;
	logic [1:0]  pbi_q, c_pbi, n_pbi;
	logic [23:0] colour_q, c_colour, n_colour;
	logic [31:0] base_q, c_base, n_base;

	logic        sof;
	logic [7:0]  b;
	logic [23:0] colour_new;
	logic        pix_done;
	logic [7:0]  alpha_v;
	logic [15:0] room;
	logic [7:0]  run_len;
	logic [15:0] col_sum;
	logic        row_end;
	logic [15:0] row_inc;
	logic        img_done;
	logic [31:0] base_step;
	logic [15:0] h_m1;
	logic [31:0] prod;
	logic        enter;

	assign sof = word_s1.start_of_file;
	assign b   = word_s1.byte_value;

	// start of file acts as a reset ahead of this byte
	always_comb begin
		if (sof) begin
			c_phase  = tgad_pkg::PH_HEADER;
			c_hcount = '0;
			c_idskip = '0;
			c_rle    = 1'b0;
			c_width  = '0;
			c_height = '0;
			c_alpha  = 1'b0;
			c_flip   = 1'b0;
			c_row    = '0;
			c_col    = '0;
			c_left   = '0;
			c_rep    = 1'b0;
			c_pbi    = '0;
			c_colour = '0;
			c_base   = '0;
		end else begin
			c_phase  = phase_q;
			c_hcount = hcount_q;
			c_idskip = idskip_q;
			c_rle    = rle_q;
			c_width  = width_q;
			c_height = height_q;
			c_alpha  = alpha_q;
			c_flip   = flip_q;
			c_row    = row_q;
			c_col    = col_q;
			c_left   = left_q;
			c_rep    = rep_q;
			c_pbi    = pbi_q;
			c_colour = colour_q;
			c_base   = base_q;
		end
	end

	// pixel byte assembly, bgr(a) order
	always_comb begin
		colour_new = c_colour;
		case (c_pbi)
			2'd0:    colour_new[7:0]   = b;
			2'd1:    colour_new[15:8]  = b;
			2'd2:    colour_new[23:16] = b;
			default: colour_new = c_colour;
		endcase
	end

	assign pix_done = (c_pbi == 2'd2 && !c_alpha) || c_pbi == 2'd3;
	assign alpha_v  = c_alpha ? b : tgad_pkg::ALPHA_OPAQUE;

	assign room    = c_width - c_col;
	always_comb begin
		if (c_phase == tgad_pkg::PH_PKTPIX && c_rep) begin
			run_len = ({8'h00, c_left} < room) ? c_left : room[7:0];
		end else begin
			run_len = 8'd1;
		end
	end
	assign col_sum   = c_col + {8'h00, run_len};
	assign row_end   = col_sum >= c_width;
	assign row_inc   = c_row + 16'd1;
	assign img_done  = row_inc >= c_height;
	assign base_step = c_flip ? (c_base - {16'h0000, c_width}) : (c_base + {16'h0000, c_width});
	assign h_m1      = c_height - 16'd1;
	assign prod      = {16'h0000, h_m1} * {16'h0000, c_width};

	always_comb begin
		n_phase   = c_phase;
		n_hcount  = c_hcount;
		n_idskip  = c_idskip;
		n_rle     = c_rle;
		n_width   = c_width;
		n_height  = c_height;
		n_alpha   = c_alpha;
		n_flip    = c_flip;
		n_row     = c_row;
		n_col     = c_col;
		n_left    = c_left;
		n_rep     = c_rep;
		n_pbi     = c_pbi;
		n_colour  = c_colour;
		n_base    = c_base;
		enter     = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		unique case (c_phase)
			tgad_pkg::PH_HEADER: begin
				if (c_hcount < tgad_pkg::HDR_LEN) begin
					n_hcount = c_hcount + 5'd1;
				end
				unique case (c_hcount)
					tgad_pkg::HDR_ID_LEN: n_idskip = b;
					tgad_pkg::HDR_TYPE: begin
						if (b == tgad_pkg::TYPE_RAW) begin
							n_rle = 1'b0;
						end else if (b == tgad_pkg::TYPE_RLE) begin
							n_rle = 1'b1;
						end else begin
							n_phase    = tgad_pkg::PH_IDLE;
							n_hcount   = c_hcount;
							res_valid  = 1'b1;
							res.status = tgad_pkg::ST_BAD_TYPE;
						end
					end
					tgad_pkg::HDR_WIDTH_LO:  n_width[7:0]   = b;
					tgad_pkg::HDR_WIDTH_HI:  n_width[15:8]  = b;
					tgad_pkg::HDR_HEIGHT_LO: n_height[7:0]  = b;
					tgad_pkg::HDR_HEIGHT_HI: n_height[15:8] = b;
					tgad_pkg::HDR_DEPTH: begin
						if (b == tgad_pkg::DEPTH_24) begin
							n_alpha = 1'b0;
						end else if (b == tgad_pkg::DEPTH_32) begin
							n_alpha = 1'b1;
						end else begin
							n_phase    = tgad_pkg::PH_IDLE;
							n_hcount   = c_hcount;
							res_valid  = 1'b1;
							res.status = tgad_pkg::ST_BAD_DEPTH;
						end
					end
					tgad_pkg::HDR_DESC: begin
						n_flip = (b & tgad_pkg::ORIGIN_MASK) == 8'h00;
						if (c_idskip != 8'h00) begin
							n_phase = tgad_pkg::PH_IDSKIP;
						end else begin
							enter = 1'b1;
						end
					end
					default: ;
				endcase
			end
			tgad_pkg::PH_IDSKIP: begin
				n_idskip = c_idskip - 8'd1;
				if (n_idskip == 8'h00) begin
					enter = 1'b1;
				end
			end
			tgad_pkg::PH_PKTHDR: begin
				n_left  = {1'b0, b[6:0]} + 8'd1;
				n_rep   = b[7];
				n_pbi   = '0;
				n_phase = tgad_pkg::PH_PKTPIX;
			end
			tgad_pkg::PH_RAW, tgad_pkg::PH_PKTPIX: begin
				n_colour = colour_new;
				if (!pix_done) begin
					n_pbi = c_pbi + 2'd1;
				end else begin
					n_pbi = '0;
					if (c_phase == tgad_pkg::PH_PKTPIX) begin
						n_left  = c_rep ? 8'h00 : (c_left - 8'd1);
						n_phase = tgad_pkg::PH_PKTHDR;
						if (!row_end && n_left != 8'h00) begin
							n_phase = tgad_pkg::PH_PKTPIX;
						end
					end
					if (row_end) begin
						n_col = '0;
						n_row = row_inc;
						if (img_done) begin
							n_phase = tgad_pkg::PH_IDLE;
						end else begin
							n_base = base_step;
						end
					end else begin
						n_col = col_sum;
					end
					res_valid          = 1'b1;
					res.status         = tgad_pkg::ST_RUN;
					res.pixel_address  = c_base + {16'h0000, c_col};
					res.run_length     = run_len;
					res.red            = colour_new[23:16];
					res.green          = colour_new[15:8];
					res.blue           = colour_new[7:0];
					res.alpha          = alpha_v;
					res.image_width    = c_width;
					res.image_height   = c_height;
					res.last_pixel     = row_end && img_done;
				end
			end
			tgad_pkg::PH_IDLE: ;
			default: ;
		endcase

		if (enter) begin
			n_row  = '0;
			n_col  = '0;
			n_pbi  = '0;
			n_left = '0;
			n_rep  = 1'b0;
			if (c_width == 16'h0000 || c_height == 16'h0000) begin
				n_phase = tgad_pkg::PH_IDLE;
			end else begin
				n_base  = n_flip ? prod : 32'h0000_0000;
				n_phase = c_rle ? tgad_pkg::PH_PKTHDR : tgad_pkg::PH_RAW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tgad_pkg::PH_HEADER;
			hcount_q <= '0;
			idskip_q <= '0;
			rle_q    <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			alpha_q  <= 1'b0;
			flip_q   <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			left_q   <= '0;
			rep_q    <= 1'b0;
			pbi_q    <= '0;
			colour_q <= '0;
			base_q   <= '0;
		end else if (fire) begin
			phase_q  <= n_phase;
			hcount_q <= n_hcount;
			idskip_q <= n_idskip;
			rle_q    <= n_rle;
			width_q  <= n_width;
			height_q <= n_height;
			alpha_q  <= n_alpha;
			flip_q   <= n_flip;
			row_q    <= n_row;
			col_q    <= n_col;
			left_q   <= n_left;
			rep_q    <= n_rep;
			pbi_q    <= n_pbi;
			colour_q <= n_colour;
			base_q   <= n_base;
		end
	end

endmodule

### rtl/tgad_output_stage.sv
module tgad_output_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tgad_pkg::run_word_t res,
	tgad_run_if.source          run,
	output logic                free
);

	logic                valid_q;
	tgad_pkg::run_word_t word_q;

	assign free = !valid_q || run.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (run.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= res;
		end
	end

	assign run.valid         = valid_q;
	assign run.status        = word_q.status;
	assign run.pixel_address = word_q.pixel_address;
	assign run.run_length    = word_q.run_length;
	assign run.red           = word_q.red;
	assign run.green         = word_q.green;
	assign run.blue          = word_q.blue;
	assign run.alpha         = word_q.alpha;
	assign run.image_width   = word_q.image_width;
	assign run.image_height  = word_q.image_height;
	assign run.last_pixel    = word_q.last_pixel;

endmodule

### rtl/tga_image_stream_decoder_unit.sv
// tga image stream decoder
// data: one file byte per word, start_of_file set on header byte 0 of a new file
// run: one word per decoded pixel or repeat packet, giving status, start address,
//   length, rgba colour, image size and a last_pixel flag on the word that ends the final row
// header type 2 (raw) and type 10 (rle) at 24 or 32 bits per pixel are decoded;
//   another type or depth gives one error word, then bytes are dropped until the
//   next start_of_file
// path: a byte that completes a pixel is held in the input register, and its run word
//   is then shown from the result register
// throughput: one byte per cycle while run.ready is high; the decode state update between the
//   input register and the result register is the only loop
// stall: while run.ready is low a full result register holds, the input register
//   still takes a byte if empty, and data.ready drops once both are full
// reset: arst_n clears the valid flags of both registers and puts the parser at header byte 0
module tga_image_stream_decoder_unit (
	input logic        clk,
	input logic        arst_n,
	tgad_byte_if.sink  data,
	tgad_run_if.source run
);

	logic                 valid_s1;
	tgad_pkg::byte_word_t word_s1;
	logic                 free;
	logic                 fire;
	logic                 res_valid;
	tgad_pkg::run_word_t  res;

	assign fire = valid_s1 && free;

	tgad_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.data     (data),
		.take     (fire),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	tgad_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.word_s1   (word_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	tgad_output_stage u_output (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire && res_valid),
		.res    (res),
		.run    (run),
		.free   (free)
	);

`ifndef SYNTHESIS
	a_run_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run.valid && run.status == tgad_pkg::ST_RUN |-> run.run_length != 8'd0)
		else $error("pixel run with zero length");

	a_last_only_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		run.valid && run.last_pixel |-> run.status == tgad_pkg::ST_RUN)
		else $error("last_pixel on error word");

	a_error_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		run.valid && run.status != tgad_pkg::ST_RUN
		|-> run.pixel_address == 32'd0 && run.image_width == 16'd0)
		else $error("error word carries run fields");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!run.valid |-> data.ready)
		else $error("input blocked with empty result register");
`endif

endmodule
